>>> rtl/wss_pkg.sv
// Shared types and constants for the windowed sample statistics block.
// No dependencies; imported by every module of the block.
package wss_pkg;

   // request opcodes
   localparam logic [1:0] OP_SAMPLE = 2'd0;
   localparam logic [1:0] OP_START  = 2'd1;
   localparam logic [1:0] OP_END    = 2'd2;
   localparam logic [1:0] OP_QUERY  = 2'd3;

   // statistic modes; codes 5 to 7 answer as sum
   localparam logic [2:0] MODE_SUM   = 3'd0;
   localparam logic [2:0] MODE_AVG   = 3'd1;
   localparam logic [2:0] MODE_MIN   = 3'd2;
   localparam logic [2:0] MODE_MAX   = 3'd3;
   localparam logic [2:0] MODE_COUNT = 3'd4;

   // register indexes
   localparam logic [1:0] CSR_STAT_MODE     = 2'd0;
   localparam logic [1:0] CSR_WINDOW_LENGTH = 2'd1;
   localparam logic [1:0] CSR_WINDOW_OPEN   = 2'd2;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 9;
   localparam int VALUE_W     = 32;
   localparam int STAT_W      = 40;
   localparam int HELD_W      = 9;

   // 40-bit signed saturation bounds, held one bit wider
   localparam logic signed [STAT_W:0] SAT_MAX = 41'sd549755813887;
   localparam logic signed [STAT_W:0] SAT_MIN = -41'sd549755813888;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   typedef enum logic [2:0] {
      CMD_STORE,
      CMD_COUNT,
      CMD_START,
      CMD_END,
      CMD_QUERY
   } cmd_type;

   typedef struct packed {
      cmd_type            cmd;
      logic [VALUE_W-1:0] value;
   } entry_type;

   typedef struct packed {
      logic [2:0] stat_mode;
      logic [8:0] window_length;
      logic       open_load;
      logic       open_value;
   } cfg_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_WALK,
      BK_DIV,
      BK_DONE
   } back_state_type;

endpackage

>>> rtl/wss_front.sv
// Front end: configuration registers, request acceptance and classification.
// Depends on wss_pkg; feeds wss_queue.
module wss_front import wss_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [1:0]             req_opcode,
   input  logic signed [VALUE_W-1:0] req_sample_value,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   input  logic                   q_full,
   output logic                   push,
   output entry_type              push_entry,
   output cfg_type                cfg
);

   logic [2:0] stat_mode_ff;
   logic [2:0] stat_mode_in;
   logic [8:0] window_length_ff;
   logic [8:0] window_length_in;

   always_comb begin
      stat_mode_in     = stat_mode_ff;
      window_length_in = window_length_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_STAT_MODE:     stat_mode_in     = csr_write_data[2:0];
            CSR_WINDOW_LENGTH: window_length_in = csr_write_data[8:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stat_mode_ff     <= MODE_SUM;
         window_length_ff <= '0;
      end else begin
         stat_mode_ff     <= stat_mode_in;
         window_length_ff <= window_length_in;
      end
   end

   assign push = start & ~q_full;

   // count mode turns samples into event counting, nothing gets stored
   always_comb begin
      push_entry.value = req_sample_value;
      case (req_opcode)
         OP_SAMPLE: push_entry.cmd = (stat_mode_ff == MODE_COUNT) ? CMD_COUNT : CMD_STORE;
         OP_START:  push_entry.cmd = CMD_START;
         OP_END:    push_entry.cmd = CMD_END;
         default:   push_entry.cmd = CMD_QUERY;
      endcase
   end

   always_comb begin
      cfg.stat_mode     = stat_mode_ff;
      cfg.window_length = window_length_ff;
      cfg.open_load     = csr_write_enable && (csr_index == CSR_WINDOW_OPEN);
      cfg.open_value    = csr_write_data[0];
   end

endmodule

>>> rtl/wss_queue.sv
// Short request queue between front end and back end.
// Depends on wss_pkg.
module wss_queue import wss_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output logic      full,
   output logic      empty,
   output entry_type head
);

   entry_type           entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W-1:0]   count_in;

   assign full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> rtl/wss_back.sv
// Back end: ring store, window bookkeeping, query walk and average divider.
// Depends on wss_pkg; takes requests from wss_queue.
module wss_back import wss_pkg::*; #(
   parameter int STORE_DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cfg_type                  cfg,
   input  logic                     q_empty,
   input  entry_type                head,
   output logic                     pop,
   output logic                     rsp_strobe,
   output logic signed [STAT_W-1:0] rsp_stat_value,
   output logic                     rsp_window_empty,
   output logic [HELD_W-1:0]        rsp_samples_held
);

   localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
   localparam int IDX_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int LIM_W  = (CNT_W > 9) ? CNT_W : 9;
   localparam int SUM_W  = VALUE_W + CNT_W;
   localparam int SAT_W  = (SUM_W > STAT_W + 1) ? SUM_W : STAT_W + 1;
   localparam int DCNT_W = $clog2(SUM_W + 1);
   localparam logic [CNT_W:0] DEPTH_C = (CNT_W + 1)'(STORE_DEPTH);

   function automatic logic [IDX_W-1:0] wrap_idx(input logic [CNT_W:0] s);
      logic [CNT_W:0] t;
      t = (s >= DEPTH_C) ? s - DEPTH_C : s;
      return t[IDX_W-1:0];
   endfunction

   logic [VALUE_W-1:0] store_mem [STORE_DEPTH];

   back_state_type state_ff;
   back_state_type state_in;

   logic [IDX_W-1:0]         oldest_ff, oldest_in;
   logic [CNT_W-1:0]         fill_ff, fill_in;
   logic                     open_ff, open_in;
   logic [VALUE_W-1:0]       evt_ff, evt_in;
   logic [IDX_W-1:0]         ptr_ff, ptr_in;
   logic [CNT_W-1:0]         iss_ff, iss_in;
   logic                     rd_vld_ff, rd_vld_in;
   logic [VALUE_W-1:0]       rd_data_ff;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic signed [VALUE_W-1:0] lo_ff, lo_in;
   logic signed [VALUE_W-1:0] hi_ff, hi_in;
   logic [CNT_W-1:0]         rem_ff, rem_in;
   logic [SUM_W-1:0]         quo_ff, quo_in;
   logic [DCNT_W-1:0]        dcnt_ff, dcnt_in;
   logic                     neg_ff, neg_in;
   logic                     strobe_ff, strobe_in;
   logic signed [STAT_W-1:0] stat_ff, stat_in;
   logic                     empty_ff, empty_in;
   logic [HELD_W-1:0]        held_ff, held_in;

   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr;
   logic                     rd_en;

   // store bookkeeping
   logic [LIM_W-1:0]         wl_ext;
   logic [LIM_W-1:0]         lim_ext;
   logic [CNT_W-1:0]         limit;
   logic                     full;
   logic [IDX_W-1:0]         o1;
   logic [CNT_W-1:0]         f2;
   logic [CNT_W-1:0]         drop;
   logic [IDX_W-1:0]         st_oldest;
   logic [CNT_W-1:0]         st_fill;

   // walk, divider and result helpers
   logic                     walk_done;
   logic signed [VALUE_W-1:0] rd_val;
   logic [SUM_W-1:0]         sum_abs;
   logic [CNT_W:0]           rem_sh;
   logic                     rem_ge;
   logic signed [STAT_W-1:0] q40;
   logic signed [SAT_W-1:0]  sum_wide;
   logic signed [STAT_W-1:0] sum_sat;

   assign pop = (state_ff == BK_IDLE) && !q_empty;

   // window limit: zero or beyond the depth means the whole store
   always_comb begin
      wl_ext  = LIM_W'(cfg.window_length);
      lim_ext = ((wl_ext == '0) || (wl_ext > LIM_W'(STORE_DEPTH))) ?
                LIM_W'(STORE_DEPTH) : wl_ext;
      limit   = lim_ext[CNT_W-1:0];
   end

   // a full store overwrites its oldest entry; then trim down to the limit
   always_comb begin
      full = (fill_ff == CNT_W'(STORE_DEPTH));
      if (full) begin
         wr_addr = oldest_ff;
         o1      = wrap_idx((CNT_W + 1)'(oldest_ff) + 1'b1);
         f2      = CNT_W'(STORE_DEPTH);
      end else begin
         wr_addr = wrap_idx((CNT_W + 1)'(oldest_ff) + (CNT_W + 1)'(fill_ff));
         o1      = oldest_ff;
         f2      = fill_ff + 1'b1;
      end
      drop = f2 - limit;
      if (f2 > limit) begin
         st_oldest = wrap_idx((CNT_W + 1)'(o1) + (CNT_W + 1)'(drop));
         st_fill   = limit;
      end else begin
         st_oldest = o1;
         st_fill   = f2;
      end
   end

   always_comb begin
      walk_done = (iss_ff == fill_ff) && !rd_vld_ff;
      rd_val    = $signed(rd_data_ff);
      sum_abs   = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
      rem_sh    = {rem_ff, quo_ff[SUM_W-1]};
      rem_ge    = (rem_sh >= (CNT_W + 1)'(fill_ff));
      q40       = neg_ff ? -STAT_W'(quo_ff[VALUE_W:0]) : STAT_W'(quo_ff[VALUE_W:0]);
      sum_wide  = SAT_W'(sum_ff);
      if (sum_wide > SAT_W'(SAT_MAX)) begin
         sum_sat = STAT_W'(SAT_MAX);
      end else if (sum_wide < SAT_W'(SAT_MIN)) begin
         sum_sat = STAT_W'(SAT_MIN);
      end else begin
         sum_sat = sum_wide[STAT_W-1:0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (pop && (head.cmd == CMD_QUERY) && (cfg.stat_mode != MODE_COUNT) &&
                (fill_ff != '0)) begin
               state_in = BK_WALK;
            end
         end
         BK_WALK: begin
            if (walk_done) begin
               state_in = (cfg.stat_mode == MODE_AVG) ? BK_DIV : BK_DONE;
            end
         end
         BK_DIV: begin
            if (dcnt_ff == DCNT_W'(1)) begin
               state_in = BK_DONE;
            end
         end
         BK_DONE: state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      oldest_in = oldest_ff;
      fill_in   = fill_ff;
      open_in   = open_ff;
      evt_in    = evt_ff;
      ptr_in    = ptr_ff;
      iss_in    = iss_ff;
      rd_vld_in = 1'b0;
      sum_in    = sum_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dcnt_in   = dcnt_ff;
      neg_in    = neg_ff;
      strobe_in = 1'b0;
      stat_in   = stat_ff;
      empty_in  = empty_ff;
      held_in   = held_ff;
      wr_en     = 1'b0;
      rd_en     = 1'b0;

      if (cfg.open_load) begin
         open_in = cfg.open_value;
      end

      case (state_ff)
         BK_IDLE: begin
            if (pop) begin
               case (head.cmd)
                  CMD_STORE: begin
                     if (open_ff) begin
                        wr_en     = 1'b1;
                        oldest_in = st_oldest;
                        fill_in   = st_fill;
                     end
                  end
                  CMD_COUNT: begin
                     if (evt_ff != '1) begin
                        evt_in = evt_ff + 1'b1;
                     end
                  end
                  CMD_START: begin
                     oldest_in = '0;
                     fill_in   = '0;
                     evt_in    = '0;
                     open_in   = 1'b1;
                  end
                  CMD_END: open_in = 1'b0;
                  default: begin
                     held_in = HELD_W'(fill_ff);
                     if (cfg.stat_mode == MODE_COUNT) begin
                        strobe_in = 1'b1;
                        stat_in   = STAT_W'(evt_ff);
                        empty_in  = (evt_ff == '0);
                     end else if (fill_ff == '0) begin
                        strobe_in = 1'b1;
                        stat_in   = '0;
                        empty_in  = 1'b1;
                     end else begin
                        ptr_in = oldest_ff;
                        iss_in = '0;
                        sum_in = '0;
                        lo_in  = {1'b0, {(VALUE_W - 1){1'b1}}};
                        hi_in  = {1'b1, {(VALUE_W - 1){1'b0}}};
                     end
                  end
               endcase
            end
         end
         BK_WALK: begin
            if (iss_ff != fill_ff) begin
               rd_en     = 1'b1;
               rd_vld_in = 1'b1;
               ptr_in    = wrap_idx((CNT_W + 1)'(ptr_ff) + 1'b1);
               iss_in    = iss_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               sum_in = sum_ff + SUM_W'(rd_val);
               if (rd_val < lo_ff) lo_in = rd_val;
               if (rd_val > hi_ff) hi_in = rd_val;
            end
            if (walk_done) begin
               rem_in  = '0;
               quo_in  = sum_abs;
               neg_in  = sum_ff[SUM_W-1];
               dcnt_in = DCNT_W'(SUM_W);
            end
         end
         BK_DIV: begin
            // restoring division, one quotient bit per cycle
            if (rem_ge) begin
               rem_in = CNT_W'(rem_sh - (CNT_W + 1)'(fill_ff));
            end else begin
               rem_in = rem_sh[CNT_W-1:0];
            end
            quo_in  = {quo_ff[SUM_W-2:0], rem_ge};
            dcnt_in = dcnt_ff - 1'b1;
         end
         BK_DONE: begin
            strobe_in = 1'b1;
            empty_in  = 1'b0;
            case (cfg.stat_mode)
               MODE_AVG: stat_in = q40;
               MODE_MIN: stat_in = STAT_W'(lo_ff);
               MODE_MAX: stat_in = STAT_W'(hi_ff);
               default:  stat_in = sum_sat;
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= BK_IDLE;
         oldest_ff <= '0;
         fill_ff   <= '0;
         open_ff   <= 1'b0;
         evt_ff    <= '0;
         rd_vld_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         oldest_ff <= oldest_in;
         fill_ff   <= fill_in;
         open_ff   <= open_in;
         evt_ff    <= evt_in;
         rd_vld_ff <= rd_vld_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff   <= ptr_in;
      iss_ff   <= iss_in;
      sum_ff   <= sum_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      dcnt_ff  <= dcnt_in;
      neg_ff   <= neg_in;
      stat_ff  <= stat_in;
      empty_ff <= empty_in;
      held_ff  <= held_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= head.value;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_mem[ptr_ff];
      end
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_stat_value   = stat_ff;
   assign rsp_window_empty = empty_ff;
   assign rsp_samples_held = held_ff;

endmodule

>>> rtl/windowed_sample_statistics.sv
// Windowed sample statistics over a ring store of signed Q16.16 samples.
//
// Request channel: a request (req_opcode, req_sample_value) is taken at a clock edge
// where start is high and busy is low. busy rises while the two-entry request
// queue is full. Opcodes: sample, start of period, end of period, query.
// Result channel: each query gives one result, shown for exactly one cycle with
// rsp_strobe high; the receiver cannot stall it.
// Register port: csr_write_enable, csr_index, csr_write_data; write only while idle.
// Timing: an accepted request is registered in the queue before the back end takes
// it. Samples, start and end are each handled by the back end in its idle state. A
// query in count mode or on an empty window is answered from the idle state through
// the result registers. Otherwise the back end reads the held samples one per cycle
// from the single store read port, then runs a bit-serial divider in average mode.
// Requests queue behind it.
// Reset: synchronous; empties the window and the queue, clears the registers and
// closes the window. The store itself is not cleared and needs no clearing pass.
// Depends on wss_pkg, wss_front, wss_queue, wss_back.
module windowed_sample_statistics import wss_pkg::*; #(
   parameter int STORE_DEPTH = 256
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [1:0]                req_opcode,
   input  logic signed [VALUE_W-1:0] req_sample_value,
   output logic                      rsp_strobe,
   output logic signed [STAT_W-1:0]  rsp_stat_value,
   output logic                      rsp_window_empty,
   output logic [HELD_W-1:0]         rsp_samples_held,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_write_data
);

   logic      push;
   entry_type push_entry;
   cfg_type   cfg;
   logic      q_full;
   logic      q_empty;
   logic      pop;
   entry_type head;

   assign busy = q_full;

   wss_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .req_opcode       (req_opcode),
      .req_sample_value (req_sample_value),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .q_full           (q_full),
      .push             (push),
      .push_entry       (push_entry),
      .cfg              (cfg)
   );

   wss_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (q_full),
      .empty      (q_empty),
      .head       (head)
   );

   wss_back #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .q_empty          (q_empty),
      .head             (head),
      .pop              (pop),
      .rsp_strobe       (rsp_strobe),
      .rsp_stat_value   (rsp_stat_value),
      .rsp_window_empty (rsp_window_empty),
      .rsp_samples_held (rsp_samples_held)
   );

endmodule

>>> tb/windowed_sample_statistics_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for windowed_sample_statistics: directed and random event
// streams, a statistics predictor kept in step with accepted requests, per-field checks.
// Depends on wss_pkg and the windowed_sample_statistics RTL.
module windowed_sample_statistics_tb import wss_pkg::*; ();

   localparam int RING_DEPTH    = 256;
   localparam int SETTLE_CYCLES = 12;
   localparam int RANDOM_ITEMS  = 800;
   localparam logic [2:0] MODE_UNDEFINED = 3'd7;

   typedef enum logic [1:0] {
      PLAN_REQUEST,
      PLAN_WRITE,
      PLAN_DRAIN
   } plan_kind_type;

   typedef struct packed {
      plan_kind_type          kind;
      logic [1:0]             opcode;
      logic [VALUE_W-1:0]     value;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
   } plan_entry_type;

   typedef struct packed {
      logic [STAT_W-1:0] stat;
      logic              empty;
      logic [HELD_W-1:0] held;
   } stat_answer_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic [1:0]                req_opcode = OP_SAMPLE;
   logic signed [VALUE_W-1:0] req_sample_value = '0;
   logic                      rsp_strobe;
   logic signed [STAT_W-1:0]  rsp_stat_value;
   logic                      rsp_window_empty;
   logic [HELD_W-1:0]         rsp_samples_held;
   logic                      csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0]    csr_index = CSR_STAT_MODE;
   logic [CSR_DATA_W-1:0]     csr_write_data = '0;

   plan_entry_type  event_plan[$];
   stat_answer_type answer_queue[$];
   int              fail_count = 0;

   // predictor state
   logic signed [VALUE_W-1:0] ring_data [RING_DEPTH];
   int                        ring_head = 0;
   int                        ring_fill = 0;
   logic                      window_is_open = 1'b0;
   logic [31:0]               sample_events = '0;
   logic [2:0]                mode_reg = MODE_SUM;
   logic [CSR_DATA_W-1:0]     length_reg = '0;

   int planned_items = 0;

   // driver pacing
   int burst_left = 20;
   int gap_left = 0;
   int settle_cycles = 0;

   windowed_sample_statistics #(
      .STORE_DEPTH(RING_DEPTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_opcode(req_opcode),
      .req_sample_value(req_sample_value),
      .rsp_strobe(rsp_strobe),
      .rsp_stat_value(rsp_stat_value),
      .rsp_window_empty(rsp_window_empty),
      .rsp_samples_held(rsp_samples_held),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic apply_write(input logic [CSR_INDEX_W-1:0] idx,
                              input logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_STAT_MODE:     mode_reg = data[2:0];
         CSR_WINDOW_LENGTH: length_reg = data;
         CSR_WINDOW_OPEN:   window_is_open = data[0];
         default: ;
      endcase
   endtask

   task automatic apply_event(input logic [1:0] op, input logic [VALUE_W-1:0] value);
      int              limit;
      longint          total, low, high, x, stat;
      stat_answer_type ans;
      case (op)
         OP_SAMPLE: begin
            if (mode_reg == MODE_COUNT) begin
               if (sample_events != '1)
                  sample_events++;
            end else if (window_is_open) begin
               limit = (length_reg == 0 || length_reg > RING_DEPTH) ? RING_DEPTH : length_reg;
               if (ring_fill >= RING_DEPTH) begin
                  ring_head = (ring_head + 1) % RING_DEPTH;
                  ring_fill = RING_DEPTH - 1;
               end
               ring_data[(ring_head + ring_fill) % RING_DEPTH] = value;
               ring_fill++;
               // a shortened length trims the oldest samples here
               if (ring_fill > limit) begin
                  ring_head = (ring_head + ring_fill - limit) % RING_DEPTH;
                  ring_fill = limit;
               end
            end
         end
         OP_START: begin
            ring_head = 0;
            ring_fill = 0;
            sample_events = '0;
            window_is_open = 1'b1;
         end
         OP_END: window_is_open = 1'b0;
         default: begin
            stat = 0;
            if (mode_reg == MODE_COUNT) begin
               stat = longint'(sample_events);
               ans.empty = (sample_events == 0);
            end else begin
               ans.empty = (ring_fill == 0);
               if (ring_fill != 0) begin
                  total = 0;
                  low = longint'(ring_data[ring_head]);
                  high = low;
                  for (int i = 0; i < ring_fill; i++) begin
                     x = longint'(ring_data[(ring_head + i) % RING_DEPTH]);
                     total += x;
                     if (x < low) low = x;
                     if (x > high) high = x;
                  end
                  case (mode_reg)
                     MODE_AVG: stat = total / ring_fill;
                     MODE_MIN: stat = low;
                     MODE_MAX: stat = high;
                     default: begin
                        if (total > SAT_MAX) stat = longint'(SAT_MAX);
                        else if (total < SAT_MIN) stat = longint'(SAT_MIN);
                        else stat = total;
                     end
                  endcase
               end
            end
            ans.stat = stat[STAT_W-1:0];
            ans.held = ring_fill[HELD_W-1:0];
            answer_queue = {answer_queue, ans};
         end
      endcase
   endtask

   task automatic push_request(input logic [1:0] op, input logic [VALUE_W-1:0] value);
      plan_entry_type entry;
      entry.kind = PLAN_REQUEST;
      entry.opcode = op;
      entry.value = value;
      entry.index = CSR_STAT_MODE;
      entry.data = '0;
      planned_items++;
      event_plan = {event_plan, entry};
   endtask

   task automatic push_write(input logic [CSR_INDEX_W-1:0] idx,
                             input logic [CSR_DATA_W-1:0] data);
      plan_entry_type entry;
      entry.kind = PLAN_WRITE;
      entry.opcode = OP_SAMPLE;
      entry.value = '0;
      entry.index = idx;
      entry.data = data;
      event_plan = {event_plan, entry};
   endtask

   // unused upper data bits carry noise
   task automatic write_mode(input logic [2:0] mode);
      logic [CSR_DATA_W-1:0] data;
      data = CSR_DATA_W'($urandom());
      data[2:0] = mode;
      push_write(CSR_STAT_MODE, data);
   endtask

   task automatic write_open(input logic open_value);
      logic [CSR_DATA_W-1:0] data;
      data = CSR_DATA_W'($urandom());
      data[0] = open_value;
      push_write(CSR_WINDOW_OPEN, data);
   endtask

   task automatic write_length(input int len);
      push_write(CSR_WINDOW_LENGTH, CSR_DATA_W'(len));
   endtask

   task automatic push_drain();
      plan_entry_type entry;
      entry = '0;
      entry.kind = PLAN_DRAIN;
      event_plan = {event_plan, entry};
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2, 3: return $urandom_range(0, 31) - 16;  // small values probe truncation
         default: return $urandom();
      endcase
   endfunction

   function automatic int pick_length();
      case ($urandom_range(0, 7))
         0: return 0;
         1: return 1;
         2: return $urandom_range(2, 8);
         3: return $urandom_range(9, 64);
         4: return 255;
         5: return 256;
         6: return $urandom_range(257, 511);
         default: return $urandom_range(2, 40);
      endcase
   endfunction

   // driver: one request or register write at a time from event_plan
   always @(posedge clock) begin : drive
      plan_entry_type head;
      logic           next_start;
      logic           next_write;
      if (reset) begin
         start <= 1'b0;
         csr_write_enable <= 1'b0;
      end else begin
         next_start = start;
         next_write = 1'b0;
         if (csr_write_enable)
            apply_write(csr_index, csr_write_data);
         if (start && !busy) begin
            apply_event(req_opcode, req_sample_value);
            next_start = 1'b0;
         end
         if (answer_queue.size() == 0 && !start)
            settle_cycles++;
         else
            settle_cycles = 0;
         if (!next_start && !csr_write_enable) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (event_plan.size() > 0) begin
               head = event_plan[0];
               case (head.kind)
                  PLAN_REQUEST: begin
                     head = event_plan.pop_front();
                     next_start = 1'b1;
                     req_opcode <= head.opcode;
                     req_sample_value <= head.value;
                     if (burst_left > 1) begin
                        burst_left--;
                     end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                     end
                  end
                  // writes and drains wait for an idle block
                  PLAN_WRITE: begin
                     if (settle_cycles >= SETTLE_CYCLES) begin
                        head = event_plan.pop_front();
                        next_write = 1'b1;
                        csr_index <= head.index;
                        csr_write_data <= head.data;
                     end
                  end
                  default: begin
                     if (settle_cycles >= SETTLE_CYCLES)
                        head = event_plan.pop_front();
                  end
               endcase
            end
         end
         start <= next_start;
         csr_write_enable <= next_write;
      end
   end

   always @(posedge clock) begin : check
      stat_answer_type want;
      if (!reset && rsp_strobe) begin
         if (answer_queue.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual stat %h empty %b held %0d",
                     $time, rsp_stat_value, rsp_window_empty, rsp_samples_held);
            fail_count++;
         end else begin
            want = answer_queue.pop_front();
            if (rsp_stat_value !== want.stat) begin
               $display("%0t: stat_value expected %h, actual %h",
                        $time, want.stat, rsp_stat_value);
               fail_count++;
            end
            if (rsp_window_empty !== want.empty) begin
               $display("%0t: window_empty expected %b, actual %b",
                        $time, want.empty, rsp_window_empty);
               fail_count++;
            end
            if (rsp_samples_held !== want.held) begin
               $display("%0t: samples_held expected %0d, actual %0d",
                        $time, want.held, rsp_samples_held);
               fail_count++;
            end
         end
      end
   end

   initial begin : stimulus
      int span;
      int pick;
      int phase;

      push_request(OP_SAMPLE, 32'h0001_0000);   // window closed after reset: dropped
      push_request(OP_QUERY, '0);               // empty window
      push_request(OP_START, '0);
      push_request(OP_SAMPLE, 32'h7FFF_FFFF);
      push_request(OP_SAMPLE, 32'h8000_0000);
      push_request(OP_SAMPLE, 32'h0000_0000);
      push_request(OP_SAMPLE, 32'hFFFF_FFFF);
      push_request(OP_SAMPLE, 32'hFFFF_FFFD);
      push_request(OP_QUERY, '1);
      push_request(OP_END, '0);
      push_request(OP_SAMPLE, 32'h0000_0005);   // closed again: dropped
      push_request(OP_QUERY, '0);
      push_drain();
      write_mode(MODE_AVG);
      write_open(1'b1);                         // register write reopens the window
      push_request(OP_SAMPLE, 32'h0000_0002);
      push_request(OP_QUERY, '0);               // negative fraction truncates to zero
      write_mode(MODE_MIN);
      push_request(OP_QUERY, '0);
      write_mode(MODE_MAX);
      push_request(OP_QUERY, '0);
      write_mode(MODE_COUNT);
      push_request(OP_SAMPLE, 32'h1234_5678);
      push_request(OP_SAMPLE, 32'h8765_4321);
      push_request(OP_QUERY, '0);
      write_mode(MODE_UNDEFINED);
      push_request(OP_QUERY, '0);
      write_length(2);
      push_request(OP_QUERY, '0);               // shorter length not applied yet
      push_request(OP_SAMPLE, 32'h0000_0100);
      push_request(OP_QUERY, '0);

      planned_items = 0;
      phase = 0;
      while (planned_items < RANDOM_ITEMS) begin
         if (phase == 0) begin
            // run past the ring depth with no length limit so the ring wraps
            write_mode(MODE_SUM);
            write_length(0);
            push_request(OP_START, $urandom());
            for (int k = 1; k <= 290; k++) begin
               push_request(OP_SAMPLE, pick_value());
               if (k % 29 == 0)
                  push_request(OP_QUERY, $urandom());
            end
            write_mode(MODE_MIN);
            push_request(OP_QUERY, $urandom());
            write_mode(MODE_AVG);
            push_request(OP_QUERY, $urandom());
            write_mode(MODE_MAX);
            push_request(OP_QUERY, $urandom());
         end else begin
            if (phase == 1) begin
               write_mode(MODE_MAX);
               write_length(511);
            end else begin
               write_mode(3'($urandom_range(0, 7)));
               if ($urandom_range(0, 1) == 1)
                  write_length(pick_length());
            end
            if ($urandom_range(0, 3) == 0)
               write_open(1'($urandom_range(0, 1)));
            if ($urandom_range(0, 3) != 0)
               push_request(OP_START, $urandom());
            span = $urandom_range(20, 60);
            repeat (span) begin
               pick = $urandom_range(0, 99);
               if (pick < 60) push_request(OP_SAMPLE, pick_value());
               else if (pick < 85) push_request(OP_QUERY, $urandom());
               else if (pick < 90) push_request(OP_END, $urandom());
               else if (pick < 95) push_request(OP_START, $urandom());
               else if (pick < 97) push_drain();
               else push_request(2'($urandom_range(0, 3)), $urandom());
            end
         end
         phase++;
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (event_plan.size() != 0 || start || csr_write_enable || answer_queue.size() != 0)
         @(posedge clock);
      repeat (400) @(posedge clock);
      if (fail_count == 0 && answer_queue.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin : watchdog
      #30_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

>>> files.f
rtl/wss_pkg.sv
rtl/wss_front.sv
rtl/wss_queue.sv
rtl/wss_back.sv
rtl/windowed_sample_statistics.sv
tb/windowed_sample_statistics_tb.sv
